// File: sv/eqb_pkg.sv
// ----------------------------------------------------------------------------
// eqb_pkg
// Shared types, codes and sizes for the epoch quiesce barrier unit.
// ----------------------------------------------------------------------------
package eqb_pkg;

    localparam int WORKERS = 8;
    localparam int DOMAINS = 4;

    localparam int W_IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int D_IDX_W = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam int MAX_N   = (WORKERS > DOMAINS) ? WORKERS : DOMAINS;
    localparam int CNT_W   = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    localparam logic [31:0] EPOCH_MAX = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [3:0] MODE_STOP      = 4'd0;
    localparam logic [3:0] MODE_POLL      = 4'd1;
    localparam logic [3:0] MODE_PARKED    = 4'd2;
    localparam logic [3:0] MODE_DRAIN     = 4'd3;
    localparam logic [3:0] MODE_RECLAIM   = 4'd4;
    localparam logic [3:0] MODE_PREPARE   = 4'd5;
    localparam logic [3:0] MODE_RELEASE   = 4'd6;
    localparam logic [3:0] MODE_REFRESHED = 4'd7;
    localparam logic [3:0] MODE_ARM       = 4'd8;
    localparam logic [3:0] MODE_INIT      = 4'd9;

    // poll verdicts
    localparam logic [1:0] ACT_FAULT   = 2'd0;
    localparam logic [1:0] ACT_PARK    = 2'd1;
    localparam logic [1:0] ACT_REFRESH = 2'd2;
    localparam logic [1:0] ACT_RUN     = 2'd3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  worker;
        logic [7:0]  domain;
        logic [31:0] epoch;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [31:0] epoch_out;
        logic [1:0]  action;
    } t_out_word;

    // control of the shared mark comparator
    typedef struct packed {
        logic clr;
        logic en;
    } t_cmp_ctl;

endpackage

// File: sv/eqb_cmp_unit.sv
// ----------------------------------------------------------------------------
// eqb_cmp_unit
// Shared 32-bit mark comparator with an all-equal accumulator, fed one
// stored mark per cycle by the sequencer.
// ----------------------------------------------------------------------------
module eqb_cmp_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eqb_pkg::t_cmp_ctl i_ctl,
    input  logic [31:0]       i_mark,
    input  logic [31:0]       i_target,
    output logic              o_all_eq
);

    logic r_all_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_eq <= 1'b1;
        end else if (i_ctl.clr) begin
            r_all_eq <= 1'b1;
        end else if (i_ctl.en) begin
            r_all_eq <= r_all_eq & (i_mark == i_target);
        end
    end

    assign o_all_eq = r_all_eq;

endmodule

// File: sv/epoch_quiesce_barrier_unit.sv
// ----------------------------------------------------------------------------
// epoch_quiesce_barrier_unit
// Epoch quiesce barrier: one operation per input word, one result word each.
// ----------------------------------------------------------------------------
// Path: stop, refreshed, init and unused codes go to EXEC, poll via POLL;
//   parked query and drain walk the parked marks; reclaimable query, prepare
//   and release walk them, then the drained marks; arm walks the ready marks;
//   a stalled result word holds EXEC. Throughput: one word at a time, the next
//   taken as the result appears; the single comparator walks one mark per cycle.
// Reset (and init): request epoch 1, other epochs, marks, fault cleared at once.
// ----------------------------------------------------------------------------
module epoch_quiesce_barrier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  eqb_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output eqb_pkg::t_out_word o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PARK,
        S_DRAIN,
        S_READY,
        S_POLL,
        S_EXEC
    } t_state;

    t_state                     r_state;
    eqb_pkg::t_in_word          r_item;
    logic [eqb_pkg::CNT_W-1:0]  r_idx;
    logic [31:0]                r_req;
    logic [31:0]                r_rel;
    logic [31:0]                r_arm;
    logic [31:0]                r_prep;
    logic                       r_fault;
    logic [31:0]                r_parked  [eqb_pkg::WORKERS];
    logic [31:0]                r_ready   [eqb_pkg::WORKERS];
    logic [31:0]                r_drained [eqb_pkg::DOMAINS];
    logic                       r_out_valid;
    eqb_pkg::t_out_word         r_out;

    eqb_pkg::t_cmp_ctl          cmp_ctl;
    logic [31:0]                mark;
    logic [31:0]                target;
    logic                       all_eq;

    logic                       in_acc;
    logic                       out_free;
    logic                       w_last;
    logic                       d_last;

    eqb_pkg::t_out_word         res;
    logic                       wk_ok;
    logic                       dm_ok;
    logic                       stopped;
    logic                       set_req;
    logic                       set_fault;
    logic                       wr_park;
    logic                       wr_ready;
    logic                       wr_drain;
    logic                       set_prep;
    logic                       set_rel;
    logic                       set_arm;
    logic                       do_init;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign w_last   = (r_idx == eqb_pkg::CNT_W'(eqb_pkg::WORKERS - 1));
    assign d_last   = (r_idx == eqb_pkg::CNT_W'(eqb_pkg::DOMAINS - 1));

    // one read address into the mark arrays: scan index, or the worker on poll
    always_comb begin
        case (r_state)
            S_PARK:  mark = r_parked[r_idx[eqb_pkg::W_IDX_W-1:0]];
            S_DRAIN: mark = r_drained[r_idx[eqb_pkg::D_IDX_W-1:0]];
            default: mark = r_ready[r_idx[eqb_pkg::W_IDX_W-1:0]];
        endcase
    end

    assign target      = (r_item.mode == eqb_pkg::MODE_POLL) ? r_req : r_item.epoch;
    assign cmp_ctl.clr = in_acc;
    assign cmp_ctl.en  = (r_state == S_PARK) || (r_state == S_DRAIN) ||
                         (r_state == S_READY) || (r_state == S_POLL);

    eqb_cmp_unit u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (cmp_ctl),
        .i_mark   (mark),
        .i_target (target),
        .o_all_eq (all_eq)
    );

    // final verdict once the scans are done
    always_comb begin
        wk_ok     = r_item.worker < 8'(eqb_pkg::WORKERS);
        dm_ok     = r_item.domain < 8'(eqb_pkg::DOMAINS);
        stopped   = (r_item.epoch != '0) && !r_fault && (r_req == r_item.epoch) &&
                    (r_rel != r_item.epoch);
        res       = '0;
        set_req   = 1'b0;
        set_fault = 1'b0;
        wr_park   = 1'b0;
        wr_ready  = 1'b0;
        wr_drain  = 1'b0;
        set_prep  = 1'b0;
        set_rel   = 1'b0;
        set_arm   = 1'b0;
        do_init   = 1'b0;
        unique case (r_item.mode) inside
            eqb_pkg::MODE_STOP: begin
                if (r_fault || r_req == '0) begin
                    res.epoch_out = '0;
                end else if (r_rel != r_req) begin
                    res.epoch_out = r_req;
                end else if (r_req == eqb_pkg::EPOCH_MAX) begin
                    set_fault = 1'b1;
                end else begin
                    set_req       = 1'b1;
                    res.epoch_out = r_req + 32'd1;
                end
                res.ok = (res.epoch_out != '0);
            end
            eqb_pkg::MODE_POLL: begin
                res.epoch_out = r_req;
                if (!wk_ok || r_req == '0 || r_fault) begin
                    res.action = eqb_pkg::ACT_FAULT;
                end else if (r_rel != r_req) begin
                    wr_park    = 1'b1;
                    res.action = eqb_pkg::ACT_PARK;
                end else if (!all_eq) begin
                    res.action = eqb_pkg::ACT_REFRESH;
                end else if (r_arm != r_req) begin
                    res.action = eqb_pkg::ACT_PARK;
                end else begin
                    res.action = eqb_pkg::ACT_RUN;
                end
                res.ok = (res.action != eqb_pkg::ACT_FAULT);
            end
            eqb_pkg::MODE_PARKED, eqb_pkg::MODE_RECLAIM: begin
                res.ok = stopped && all_eq;
            end
            eqb_pkg::MODE_DRAIN: begin
                if (dm_ok && stopped && all_eq) begin
                    wr_drain = 1'b1;
                    res.ok   = 1'b1;
                end
            end
            eqb_pkg::MODE_PREPARE: begin
                if (stopped && all_eq) begin
                    set_prep = 1'b1;
                    res.ok   = 1'b1;
                end
            end
            eqb_pkg::MODE_RELEASE: begin
                if (stopped && all_eq && r_prep == r_item.epoch) begin
                    set_rel = 1'b1;
                    res.ok  = 1'b1;
                end
            end
            eqb_pkg::MODE_REFRESHED: begin
                if (wk_ok && r_item.epoch != '0 && !r_fault &&
                    r_req == r_item.epoch && r_rel == r_item.epoch) begin
                    wr_ready = 1'b1;
                    res.ok   = 1'b1;
                end
            end
            eqb_pkg::MODE_ARM: begin
                if (r_item.epoch != '0 && !r_fault && r_req == r_item.epoch &&
                    r_rel == r_item.epoch && r_prep == r_item.epoch && all_eq) begin
                    set_arm = 1'b1;
                    res.ok  = 1'b1;
                end
            end
            eqb_pkg::MODE_INIT: begin
                do_init = 1'b1;
                res.ok  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_req       <= 32'd1;
            r_rel       <= '0;
            r_arm       <= '0;
            r_prep      <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < eqb_pkg::WORKERS; i++) begin
                r_parked[i] <= '0;
                r_ready[i]  <= '0;
            end
            for (int i = 0; i < eqb_pkg::DOMAINS; i++) begin
                r_drained[i] <= '0;
            end
        end else begin
            // a finishing operation reloads the output word itself
            if (r_out_valid && !i_out_stall && r_state != S_EXEC) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_idx  <= (i_in_data.mode == eqb_pkg::MODE_POLL) ?
                                  i_in_data.worker[eqb_pkg::CNT_W-1:0] : '0;
                        if (i_in_data.mode == eqb_pkg::MODE_POLL) begin
                            r_state <= S_POLL;
                        end else if (i_in_data.mode inside {eqb_pkg::MODE_PARKED,
                                     eqb_pkg::MODE_DRAIN, eqb_pkg::MODE_RECLAIM,
                                     eqb_pkg::MODE_PREPARE, eqb_pkg::MODE_RELEASE}) begin
                            r_state <= S_PARK;
                        end else if (i_in_data.mode == eqb_pkg::MODE_ARM) begin
                            r_state <= S_READY;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_PARK: begin
                    if (w_last) begin
                        r_idx <= '0;
                        if (r_item.mode inside {eqb_pkg::MODE_RECLAIM,
                            eqb_pkg::MODE_PREPARE, eqb_pkg::MODE_RELEASE}) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end else begin
                        r_idx <= r_idx + eqb_pkg::CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (d_last) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + eqb_pkg::CNT_W'(1);
                    end
                end
                S_READY: begin
                    if (w_last) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + eqb_pkg::CNT_W'(1);
                    end
                end
                S_POLL: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= res;
                        r_state     <= S_IDLE;
                        if (set_req) begin
                            r_req <= r_req + 32'd1;
                        end
                        if (set_fault) begin
                            r_fault <= 1'b1;
                        end
                        if (wr_park) begin
                            r_parked[r_item.worker[eqb_pkg::W_IDX_W-1:0]] <= r_req;
                        end
                        if (wr_ready) begin
                            r_ready[r_item.worker[eqb_pkg::W_IDX_W-1:0]] <= r_item.epoch;
                        end
                        if (wr_drain) begin
                            r_drained[r_item.domain[eqb_pkg::D_IDX_W-1:0]] <= r_item.epoch;
                        end
                        if (set_prep) begin
                            r_prep <= r_item.epoch;
                        end
                        if (set_rel) begin
                            r_rel <= r_item.epoch;
                        end
                        if (set_arm) begin
                            r_arm <= r_item.epoch;
                        end
                        if (do_init) begin
                            r_req   <= 32'd1;
                            r_rel   <= '0;
                            r_arm   <= '0;
                            r_prep  <= '0;
                            r_fault <= 1'b0;
                            for (int i = 0; i < eqb_pkg::WORKERS; i++) begin
                                r_parked[i] <= '0;
                                r_ready[i]  <= '0;
                            end
                            for (int i = 0; i < eqb_pkg::DOMAINS; i++) begin
                                r_drained[i] <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted word always leaves the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block not busy next cycle");

    // a result appears only as the operation completes and input reopens
    a_result_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (!o_in_stall && $past(o_in_stall)))
        else $error("result appeared outside operation completion");

    // the request epoch never wraps to zero
    a_req_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_req != '0))
        else $error("request epoch reached zero");

endmodule
